@@ sv/tkht_pkg.sv @@
// ----------------------------------------------------------------------------
// tkht_pkg: shared types and helpers
// Commands, kind codes, state encoding and the key hash and match functions.
// ----------------------------------------------------------------------------
package tkht_pkg;

  localparam int SLOTS_DEFAULT = 64;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  localparam logic [2:0] KIND_INT   = 3'd1;
  localparam logic [2:0] KIND_FLOAT = 3'd2;

  // One slot: key kind, key bits, value kind, value bits.
  typedef struct packed {
    logic [2:0]  kk;
    logic [63:0] kb;
    logic [2:0]  vk;
    logic [63:0] vb;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_RM_RD,
    ST_RM_CHK,
    ST_RI_RD,
    ST_RI_CHK,
    ST_DONE
  } state_t;

  function automatic logic [31:0] key_hash(input logic [2:0] k, input logic [63:0] b);
    if (k == KIND_INT || k == KIND_FLOAT) return b[31:0] ^ b[63:32];
    return b[31:0];
  endfunction

  function automatic logic is_nan(input logic [63:0] b);
    return (&b[62:52]) && (|b[51:0]);
  endfunction

  function automatic logic keys_match(input logic [2:0] ka, input logic [63:0] a,
                                      input logic [2:0] kb, input logic [63:0] b);
    if (ka != kb) return 1'b0;
    if (ka == KIND_FLOAT) begin
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if (((a | b) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0) return 1'b1;
    end
    return a == b;
  endfunction

endpackage

@@ sv/typed_key_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// typed_key_hash_table_core: linear-probing key-value table
// ----------------------------------------------------------------------------
// Each request (insert/update, lookup, remove or spare) yields one result.
// The slot contents sit in one single-port RAM and the occupancy bits in
// flip-flops cleared by reset, so the table is usable at once. Each slot a
// request probes is read in ST_PRB_RD and checked in ST_PRB_CHK; the result
// is formed in ST_DONE. A remove that hits then walks the following cluster:
// each entry still in it is read in ST_RM_RD and lifted out in ST_RM_CHK,
// its re-insert probe checks its home slot in ST_RI_CHK and every further
// slot in ST_RI_RD and ST_RI_CHK; an empty slot ends the walk. One request
// is handled at a time; the result waits in an output register until taken.
module typed_key_hash_table_core
  import tkht_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[1:0], key_kind[4:2], key_bits[68:5], value_kind[71:69],
  // value_bits[135:72]
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found[0], result_kind[3:1], result_bits[67:4], status[68], entries_now[74:69]
  output logic [79:0]  out_tdata
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t state_r, state_nxt;
  logic [1:0]  cmd_r;
  slot_t       req_r;          // key and value of the request or moving entry
  logic [AW-1:0] idx_r, hole_r;
  logic [AW:0] steps_r;
  logic [CW-1:0] total_r;
  logic [SLOTS-1:0] used_r;
  logic        hit_r;
  logic [2:0]  rk_r;
  logic [63:0] rb_r;
  logic        stat_r;
  logic [79:0] out_r;
  logic        outv_r;

  logic          we;
  logic [AW-1:0] addr;
  slot_t         wdata, rdata;

  tkht_ram #(.WIDTH($bits(slot_t)), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_tready  = (state_r == ST_IDLE) && !outv_r;
  assign out_tvalid = outv_r;
  assign out_tdata  = out_r;

  logic at_limit;
  assign at_limit = ({1'b0, total_r, 1'b0} >= (CW+2)'(SLOTS));

  logic [AW-1:0] in_home, rdata_home;
  assign in_home    = AW'(key_hash(in_tdata[4:2], in_tdata[68:5]));
  assign rdata_home = AW'(key_hash(rdata.kk, rdata.kb));

  logic slot_hit;
  assign slot_hit = used_r[idx_r] && keys_match(rdata.kk, rdata.kb, req_r.kk, req_r.kb);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_tvalid && in_tready) state_nxt = ST_PRB_RD;
      ST_PRB_RD:  state_nxt = ST_PRB_CHK;
      ST_PRB_CHK: begin
        if (!used_r[idx_r] || slot_hit || steps_r == (AW+1)'(SLOTS - 1)) begin
          if (cmd_r == CMD_REMOVE && slot_hit) state_nxt = ST_RM_RD;
          else state_nxt = ST_DONE;
        end else state_nxt = ST_PRB_RD;
      end
      ST_RM_RD:   state_nxt = used_r[idx_r] ? ST_RM_CHK : ST_DONE;
      ST_RM_CHK:  state_nxt = ST_RI_CHK;
      ST_RI_RD:   state_nxt = ST_RI_CHK;
      ST_RI_CHK:  state_nxt = used_r[idx_r] ? ST_RI_RD : ST_RM_RD;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Memory port and write data.
  always_comb begin
    we = 1'b0;
    addr = idx_r;
    wdata = req_r;
    case (state_r)
      ST_PRB_CHK: begin
        if (cmd_r == CMD_PUT && (slot_hit || (!used_r[idx_r] && !at_limit))) we = 1'b1;
      end
      ST_RI_CHK: if (!used_r[idx_r]) we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      total_r <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (outv_r && out_tready) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          cmd_r   <= in_tdata[1:0];
          req_r   <= '{kk: in_tdata[4:2], kb: in_tdata[68:5],
                       vk: in_tdata[71:69], vb: in_tdata[135:72]};
          idx_r   <= in_home;
          steps_r <= '0;
          hit_r   <= 1'b0;
          rk_r    <= KIND_INT;
          rb_r    <= '0;
          stat_r  <= 1'b0;
        end
        ST_PRB_CHK: begin
          if (slot_hit) begin
            hit_r <= 1'b1;
            rk_r  <= rdata.vk;
            rb_r  <= rdata.vb;
          end
          if (!used_r[idx_r] || slot_hit || steps_r == (AW+1)'(SLOTS - 1)) begin
            if (cmd_r == CMD_PUT) begin
              if (slot_hit) ;
              else if (!used_r[idx_r] && !at_limit) begin
                used_r[idx_r] <= 1'b1;
                total_r <= total_r + 1'b1;
              end else stat_r <= 1'b1;
            end else if (cmd_r == CMD_REMOVE && slot_hit) begin
              used_r[idx_r] <= 1'b0;
              total_r <= total_r - 1'b1;
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            steps_r <= steps_r + 1'b1;
          end
        end
        // Cluster entry at idx_r read; pull it out and re-probe from its home.
        ST_RM_CHK: begin
          req_r   <= rdata;
          hole_r  <= idx_r;
          used_r[idx_r] <= 1'b0;
          idx_r   <= rdata_home;
        end
        ST_RI_CHK: begin
          // Keys in the table are unique, so only an empty slot ends the walk.
          if (!used_r[idx_r]) begin
            used_r[idx_r] <= 1'b1;
            idx_r <= hole_r + 1'b1;
          end else idx_r <= idx_r + 1'b1;
        end
        ST_DONE: begin
          out_r  <= {5'd0, 6'(total_r), stat_r, rb_r, rk_r, hit_r};
          outv_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ sv/tkht_ram.sv @@
// ----------------------------------------------------------------------------
// tkht_ram: generic single-port RAM
// One access per cycle, writing when we is set; read data registered (old data on a write).
// ----------------------------------------------------------------------------
module tkht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ sv/tkht_checker.sv @@
// ----------------------------------------------------------------------------
// tkht_checker: port-level checks
// Watches the handshakes and result fields of the table core.
// ----------------------------------------------------------------------------
module tkht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[67:4] == 64'd0 && out_tdata[3:1] == 3'd1)
    else $error("miss result not int zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");
endmodule

bind typed_key_hash_table_core tkht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for typed_key_hash_table_core
// Drives insert, lookup, remove and spare requests over the input stream and checks
// every result against a behavioural table model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
  import tkht_pkg::*;
;

  localparam int NSLOTS    = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int NRANDOM   = 750;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [79:0]  out_tdata;

  typedef struct packed {
    logic [5:0]  entries_now;
    logic        status;
    logic [63:0] result_bits;
    logic [2:0]  result_kind;
    logic        found;
  } answer_t;

  typedef struct {
    cmd_t        cmd;
    logic [2:0]  kk;
    logic [63:0] kb;
    logic [2:0]  vk;
    logic [63:0] vb;
  } request_t;

  // Bench copy of the table.
  logic        tbl_used [NSLOTS];
  slot_t       tbl_slot [NSLOTS];
  int unsigned tbl_count;

  answer_t  answers_due[$];
  request_t key_pool[$];
  int       errors;
  int       idle_cycles;

  typed_key_hash_table_core #(.SLOTS(NSLOTS)) i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic nan_bits(logic [63:0] b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
  endfunction

  function automatic logic same_key(logic [2:0] ka, logic [63:0] a,
                                    logic [2:0] kb, logic [63:0] b);
    if (ka != kb) return 1'b0;
    if (ka == KIND_FLOAT) begin
      if (nan_bits(a) || nan_bits(b)) return 1'b0;
      if (((a | b) & 64'h7FFF_FFFF_FFFF_FFFF) == 64'd0) return 1'b1;
    end
    return a == b;
  endfunction

  // Slot holding the key, else first free slot on its path, else -1.
  function automatic int find_slot(logic [2:0] k, logic [63:0] b);
    logic [31:0] h;
    int s;
    h = (k == KIND_INT || k == KIND_FLOAT) ? (b[31:0] ^ b[63:32]) : b[31:0];
    for (int i = 0; i < NSLOTS; i++) begin
      s = (h + i) % NSLOTS;
      if (!tbl_used[s] || same_key(tbl_slot[s].kk, tbl_slot[s].kb, k, b)) return s;
    end
    return -1;
  endfunction

  function automatic logic table_put(slot_t e);
    int s;
    s = find_slot(e.kk, e.kb);
    if (s < 0) return 1'b0;
    if (!tbl_used[s]) begin
      if (tbl_count * 2 >= NSLOTS) return 1'b0;
      tbl_count++;
    end
    tbl_used[s] = 1'b1;
    tbl_slot[s] = e;
    return 1'b1;
  endfunction

  function automatic answer_t table_apply(request_t r);
    answer_t a;
    slot_t   e;
    int      s, idx;
    logic    hit;
    s   = find_slot(r.kk, r.kb);
    hit = (s >= 0) && tbl_used[s];
    a.found       = hit;
    a.result_kind = hit ? tbl_slot[s].vk : KIND_INT;
    a.result_bits = hit ? tbl_slot[s].vb : 64'd0;
    a.status      = 1'b0;
    if (r.cmd == CMD_PUT) begin
      e = '{kk: r.kk, kb: r.kb, vk: r.vk, vb: r.vb};
      a.status = !table_put(e);
    end else if (r.cmd == CMD_REMOVE && hit) begin
      tbl_used[s] = 1'b0;
      tbl_count--;
      idx = (s + 1) % NSLOTS;
      // Pull each following entry of the cluster out and put it back.
      for (int n = 0; n < NSLOTS && tbl_used[idx]; n++) begin
        e = tbl_slot[idx];
        tbl_used[idx] = 1'b0;
        tbl_count--;
        void'(table_put(e));
        idx = (idx + 1) % NSLOTS;
      end
    end
    a.entries_now = tbl_count[5:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result side: random stall pattern, then compare with the oldest answer.
  initial begin
    answer_t got, want;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = answer_t'(out_tdata[74:0]);
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], 64'd0);
        end else begin
          want = answers_due.pop_front();
          if (got.found != want.found)
            report_mismatch("found", 64'(got.found), 64'(want.found));
          if (got.result_kind != want.result_kind)
            report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
          if (got.result_bits != want.result_bits)
            report_mismatch("result_bits", got.result_bits, want.result_bits);
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.entries_now != want.entries_now)
            report_mismatch("entries_now", 64'(got.entries_now), 64'(want.entries_now));
        end
      end
      // Ready with a chance of three in four, otherwise stalled.
      out_tready <= ($urandom_range(0, 3) == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired");
      $display("testbench: done, errors");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_request(request_t r, answer_t fixed, bit use_fixed);
    answer_t a;
    // Gaps between bursts; nothing here lowers a valid that is raised again.
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 1)) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {r.vb, r.vk, r.kb, r.kk, r.cmd};
    do @(posedge clk); while (!in_tready);
    a = table_apply(r);
    if (use_fixed && a != fixed)
      report_mismatch("bench model vs table row", 64'(a), 64'(fixed));
    answers_due.push_back(a);
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (key_pool.size() != 0 && $urandom_range(0, 2) != 0) begin
      r.kk = key_pool[$urandom_range(0, key_pool.size() - 1)].kk;
      r.kb = key_pool[$urandom_range(0, key_pool.size() - 1)].kb;
      if ($urandom_range(0, 1)) r = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      r.kk = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: r.kb = {$urandom, $urandom};
        1: r.kb = 64'($urandom_range(0, 255));
        // Keys that all land on home slot 5 give long clusters.
        2: r.kb = {32'd0, 24'd0, 2'($urandom_range(0, 3)), 6'd5};
        default: r.kb = {1'($urandom_range(0, 1)), 11'h7FF, 20'($urandom), 32'($urandom)};
      endcase
    end
    r.cmd = cmd_t'((pick < 45) ? CMD_PUT : (pick < 75) ? CMD_LOOKUP :
                   (pick < 97) ? CMD_REMOVE : CMD_SPARE);
    r.vk = 3'($urandom_range(0, 7));
    r.vb = {$urandom, $urandom};
    if (r.cmd == CMD_PUT && key_pool.size() < 40) key_pool.push_back(r);
    return r;
  endfunction

  // Directed rows: the answer column is typed in only where obvious.
  typedef struct {
    request_t r;
    answer_t  a;
    bit       fixed;
  } row_t;

  row_t rows[$];

  function automatic request_t rq(cmd_t c, logic [2:0] kk, logic [63:0] kb,
                                  logic [2:0] vk, logic [63:0] vb);
    request_t r;
    r = '{cmd: c, kk: kk, kb: kb, vk: vk, vb: vb};
    return r;
  endfunction

  function automatic answer_t miss(logic st, logic [5:0] n);
    answer_t a;
    a = '{entries_now: n, status: st, result_bits: 64'd0, result_kind: KIND_INT,
          found: 1'b0};
    return a;
  endfunction

  initial begin
    answer_t none;
    request_t r;
    none = '0;
    errors = 0;
    idle_cycles = 0;
    tbl_count = 0;
    for (int i = 0; i < NSLOTS; i++) tbl_used[i] = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;

    // After reset everything misses.
    rows.push_back('{rq(CMD_LOOKUP, 3'd0, 64'd0, 3'd0, 64'd0), miss(1'b0, 6'd0), 1'b1});
    rows.push_back('{rq(CMD_REMOVE, 3'd7, '1, 3'd7, '1), miss(1'b0, 6'd0), 1'b1});
    rows.push_back('{rq(CMD_PUT, 3'd1, '1, 3'd7, '1), miss(1'b0, 6'd1), 1'b1});
    rows.push_back('{rq(CMD_PUT, 3'd1, '1, 3'd0, 64'd0), none, 1'b0});
    rows.push_back('{rq(CMD_LOOKUP, 3'd1, '1, 3'd0, 64'd0), none, 1'b0});
    // Signed zero: +0 and -0 are the same float key.
    rows.push_back('{rq(CMD_PUT, KIND_FLOAT, 64'd0, 3'd2, 64'h1234), none, 1'b0});
    rows.push_back('{rq(CMD_LOOKUP, KIND_FLOAT, 64'h8000_0000_0000_0000, 3'd0, 64'd0),
                     none, 1'b0});
    // A NaN key never matches, so each insert adds an entry.
    rows.push_back('{rq(CMD_PUT, KIND_FLOAT, 64'h7FF8_0000_0000_0001, 3'd3, 64'd9),
                     none, 1'b0});
    rows.push_back('{rq(CMD_PUT, KIND_FLOAT, 64'h7FF8_0000_0000_0001, 3'd4, 64'd8),
                     none, 1'b0});
    rows.push_back('{rq(CMD_LOOKUP, KIND_FLOAT, 64'h7FF8_0000_0000_0001, 3'd0, 64'd0),
                     none, 1'b0});
    rows.push_back('{rq(CMD_REMOVE, KIND_FLOAT, 64'h7FF8_0000_0000_0001, 3'd0, 64'd0),
                     none, 1'b0});
    // Same payload, different kind, and the spare command.
    rows.push_back('{rq(CMD_PUT, 3'd6, 64'd5, 3'd5, 64'd77), none, 1'b0});
    rows.push_back('{rq(CMD_SPARE, 3'd6, 64'd5, 3'd0, 64'd0), none, 1'b0});
    rows.push_back('{rq(CMD_LOOKUP, 3'd5, 64'd5, 3'd0, 64'd0), none, 1'b0});
    // Colliding keys form a cluster; removing its head re-places the rest.
    for (int i = 0; i < 4; i++)
      rows.push_back('{rq(CMD_PUT, 3'd3, 64'(i * NSLOTS + 5), 3'd1, 64'(i)), none, 1'b0});
    rows.push_back('{rq(CMD_REMOVE, 3'd6, 64'd5, 3'd0, 64'd0), none, 1'b0});
    rows.push_back('{rq(CMD_LOOKUP, 3'd3, 64'(3 * NSLOTS + 5), 3'd0, 64'd0), none, 1'b0});
    rows.push_back('{rq(CMD_REMOVE, 3'd3, 64'(NSLOTS + 5), 3'd0, 64'd0), none, 1'b0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].r, rows[i].a, rows[i].fixed);
    // Fill to the load limit, then further new keys must be refused.
    for (int i = 0; i < NSLOTS; i++)
      send_request(rq(CMD_PUT, 3'd4, 64'(1000 + i), 3'd2, 64'(i)), none, 1'b0);
    for (int i = 0; i < NSLOTS; i++)
      send_request(rq(CMD_REMOVE, 3'd4, 64'(1000 + i), 3'd0, 64'd0), none, 1'b0);

    for (int i = 0; i < NRANDOM; i++) begin
      r = random_request();
      send_request(r, none, 1'b0);
    end
    in_tvalid <= 1'b0;

    wait (answers_due.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
